[design/modbus_rtu_master_transaction_unit_defines.svh]
// Assertion macros for the Modbus RTU master transaction unit.
`ifndef MODBUS_RTU_MASTER_TRANSACTION_UNIT_DEFINES_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRTU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mrtu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MRTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mrtu: next-cycle check failed");

`endif

[design/mrtu_pkg.sv]
`timescale 1ns / 1ps

package mrtu_pkg;

	// input commands
	localparam logic [1:0] CMD_RX   = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_SEND = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;
	localparam logic [1:0] KIND_REFUSE = 2'd3;

	// transaction outcomes
	localparam logic [2:0] OUT_OK        = 3'd0;
	localparam logic [2:0] OUT_CRC_ERR   = 3'd1;
	localparam logic [2:0] OUT_UNK_FUNC  = 3'd2;
	localparam logic [2:0] OUT_TIMEOUT   = 3'd3;
	localparam logic [2:0] OUT_EXCEPTION = 3'd4;

	// function codes
	localparam logic [7:0] FC_READ_COILS    = 8'h01;
	localparam logic [7:0] FC_READ_INPUTS   = 8'h02;
	localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
	localparam logic [7:0] FC_READ_INPUT_RG = 8'h04;
	localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
	localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;
	localparam logic [7:0] FIXED_DATA_LEN   = 8'd3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [9:0] QUIET_MAX     = 10'd1023;
	localparam logic [9:0] TIMEOUT_RESET = 10'd30;

	localparam int QUEUE_DEPTH = 4;

	// index of the final byte of a request frame
	localparam logic [2:0] FRAME_LAST = 3'd7;

	typedef enum logic [1:0] {
		JOB_SEND   = 2'd0,
		JOB_DATA   = 2'd1,
		JOB_FINISH = 2'd2,
		JOB_REFUSE = 2'd3
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  data_byte;
		logic [2:0]  outcome;
		logic [7:0]  reply_addr;
		logic [7:0]  reply_func;
		logic [7:0]  data_count;
		logic [7:0]  slave_addr;
		logic [7:0]  func_code;
		logic [15:0] first_reg;
		logic [15:0] reg_count;
	} job_t;

	// one byte of CRC-16/MODBUS, reflected
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[design/mrtu_front.sv]
`timescale 1ns / 1ps

module mrtu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        command,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        slave_addr,
	input  logic [7:0]        func_code,
	input  logic [15:0]       first_reg,
	input  logic [15:0]       reg_count,
	input  logic [9:0]        timeout_ms,
	output logic              push,
	output mrtu_pkg::job_t    push_job
);

	typedef enum logic [3:0] {
		BUS_NONE     = 4'b0001,
		BUS_PENDING  = 4'b0010,
		BUS_RECEIVED = 4'b0100,
		BUS_FAILED   = 4'b1000
	} bus_t;

	typedef enum logic [5:0] {
		STEP_ADDR   = 6'b000001,
		STEP_FUNC   = 6'b000010,
		STEP_LEN    = 6'b000100,
		STEP_DATA   = 6'b001000,
		STEP_CRC_LO = 6'b010000,
		STEP_CRC_HI = 6'b100000
	} step_t;

	bus_t        bus_q, bus_d;
	step_t       step_q, step_d;
	logic [7:0]  raddr_q, raddr_d;
	logic [7:0]  rfunc_q, rfunc_d;
	logic [7:0]  dlen_q, dlen_d;
	logic [7:0]  didx_q, didx_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [9:0]  wait_q, wait_d;
	logic [9:0]  quiet_q, quiet_d;

	logic        fin;
	logic [2:0]  fin_outcome;
	logic [7:0]  next_idx;

	always_comb begin
		bus_d       = bus_q;
		step_d      = step_q;
		raddr_d     = raddr_q;
		rfunc_d     = rfunc_q;
		dlen_d      = dlen_q;
		didx_d      = didx_q;
		crc_d       = crc_q;
		crc_lo_d    = crc_lo_q;
		wait_d      = wait_q;
		quiet_d     = quiet_q;
		push        = 1'b0;
		push_job    = '0;
		fin         = 1'b0;
		fin_outcome = mrtu_pkg::OUT_OK;
		next_idx    = didx_q + 8'd1;

		if (accept) begin
			unique case (command)
				mrtu_pkg::CMD_RX: begin
					quiet_d = '0;
					if (bus_q == BUS_PENDING) begin
						wait_d = '0;
						unique case (step_q)
							STEP_ADDR: begin
								raddr_d = rx_byte;
								didx_d  = '0;
								crc_d   = mrtu_pkg::crc_add(mrtu_pkg::CRC_INIT, rx_byte);
								step_d  = STEP_FUNC;
							end
							STEP_FUNC: begin
								rfunc_d = rx_byte;
								crc_d   = mrtu_pkg::crc_add(crc_q, rx_byte);
								step_d  = STEP_LEN;
							end
							STEP_LEN: begin
								crc_d  = mrtu_pkg::crc_add(crc_q, rx_byte);
								didx_d = '0;
								if (rfunc_q[7]) begin
									dlen_d = '0;
								end else if (rfunc_q inside {mrtu_pkg::FC_READ_COILS,
										mrtu_pkg::FC_READ_INPUTS, mrtu_pkg::FC_READ_HOLDING,
										mrtu_pkg::FC_READ_INPUT_RG}) begin
									dlen_d = rx_byte;
								end else if (rfunc_q == mrtu_pkg::FC_WRITE_COIL ||
										rfunc_q == mrtu_pkg::FC_WRITE_MULTI) begin
									dlen_d = mrtu_pkg::FIXED_DATA_LEN;
								end else begin
									fin         = 1'b1;
									fin_outcome = mrtu_pkg::OUT_UNK_FUNC;
								end
								if (!fin) begin
									step_d = (dlen_d == 8'd0) ? STEP_CRC_LO : STEP_DATA;
								end
							end
							STEP_DATA: begin
								crc_d  = mrtu_pkg::crc_add(crc_q, rx_byte);
								didx_d = next_idx;
								if (next_idx >= dlen_q) begin
									step_d = STEP_CRC_LO;
								end
								push               = 1'b1;
								push_job.kind      = mrtu_pkg::JOB_DATA;
								push_job.data_byte = rx_byte;
							end
							STEP_CRC_LO: begin
								crc_lo_d = rx_byte;
								step_d   = STEP_CRC_HI;
							end
							STEP_CRC_HI: begin
								fin = 1'b1;
								if ({rx_byte, crc_lo_q} != crc_q) begin
									fin_outcome = mrtu_pkg::OUT_CRC_ERR;
								end else if (rfunc_q[7]) begin
									fin_outcome = mrtu_pkg::OUT_EXCEPTION;
								end else begin
									fin_outcome = mrtu_pkg::OUT_OK;
								end
							end
							default: begin
								step_d = STEP_ADDR;
							end
						endcase
					end
				end
				mrtu_pkg::CMD_TICK: begin
					if (quiet_q != mrtu_pkg::QUIET_MAX) begin
						quiet_d = quiet_q + 10'd1;
					end
					if (bus_q == BUS_PENDING) begin
						if (wait_q >= timeout_ms) begin
							fin         = 1'b1;
							fin_outcome = mrtu_pkg::OUT_TIMEOUT;
						end else begin
							wait_d = wait_q + 10'd1;
						end
					end
				end
				mrtu_pkg::CMD_SEND: begin
					push = 1'b1;
					if (bus_q == BUS_PENDING || quiet_q < timeout_ms) begin
						push_job.kind = mrtu_pkg::JOB_REFUSE;
					end else begin
						push_job.kind       = mrtu_pkg::JOB_SEND;
						push_job.slave_addr = slave_addr;
						push_job.func_code  = func_code;
						push_job.first_reg  = first_reg;
						push_job.reg_count  = reg_count;
						step_d  = STEP_ADDR;
						raddr_d = '0;
						rfunc_d = '0;
						dlen_d  = '0;
						didx_d  = '0;
						crc_d   = mrtu_pkg::CRC_INIT;
						crc_lo_d = '0;
						wait_d  = '0;
						bus_d   = BUS_PENDING;
					end
				end
				default: begin
				end
			endcase

			if (fin) begin
				bus_d  = (fin_outcome == mrtu_pkg::OUT_OK) ? BUS_RECEIVED : BUS_FAILED;
				step_d = STEP_ADDR;
				wait_d = '0;
				push                = 1'b1;
				push_job.kind       = mrtu_pkg::JOB_FINISH;
				push_job.outcome    = fin_outcome;
				push_job.reply_addr = raddr_d;
				push_job.reply_func = rfunc_d;
				push_job.data_count = didx_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q    <= BUS_NONE;
			step_q   <= STEP_ADDR;
			raddr_q  <= '0;
			rfunc_q  <= '0;
			dlen_q   <= '0;
			didx_q   <= '0;
			crc_q    <= mrtu_pkg::CRC_INIT;
			crc_lo_q <= '0;
			wait_q   <= '0;
			quiet_q  <= mrtu_pkg::QUIET_MAX;
		end else begin
			bus_q    <= bus_d;
			step_q   <= step_d;
			raddr_q  <= raddr_d;
			rfunc_q  <= rfunc_d;
			dlen_q   <= dlen_d;
			didx_q   <= didx_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
			wait_q   <= wait_d;
			quiet_q  <= quiet_d;
		end
	end

endmodule

[design/mrtu_queue.sv]
`timescale 1ns / 1ps

module mrtu_queue #(
	parameter int DEPTH = mrtu_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mrtu_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output mrtu_pkg::job_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	mrtu_pkg::job_t slots_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/mrtu_back.sv]
`timescale 1ns / 1ps

module mrtu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  mrtu_pkg::job_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     out_kind,
	output logic [7:0]     out_byte,
	output logic           last,
	output logic [2:0]     outcome,
	output logic [7:0]     reply_addr,
	output logic [7:0]     reply_func,
	output logic [7:0]     data_count
);

	logic        valid_q;
	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic        emit;
	logic [7:0]  tx_byte;
	logic [15:0] crc_base;

	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [2:0]  outcome_q;
	logic [7:0]  raddr_q, rfunc_q, dcount_q;

	assign emit = !empty && (!valid_q || !out_stall);
	assign pop  = emit && (head.kind != mrtu_pkg::JOB_SEND || idx_q == mrtu_pkg::FRAME_LAST);

	// frame byte for the current index; CRC bytes come from the running sum
	always_comb begin
		case (idx_q)
			3'd0:    tx_byte = head.slave_addr;
			3'd1:    tx_byte = head.func_code;
			3'd2:    tx_byte = head.first_reg[15:8];
			3'd3:    tx_byte = head.first_reg[7:0];
			3'd4:    tx_byte = head.reg_count[15:8];
			3'd5:    tx_byte = head.reg_count[7:0];
			3'd6:    tx_byte = crc_q[7:0];
			default: tx_byte = crc_q[15:8];
		endcase
		crc_base = (idx_q == 3'd0) ? mrtu_pkg::CRC_INIT : crc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
			if (emit && head.kind == mrtu_pkg::JOB_SEND) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q    <= '0;
			last_q    <= 1'b0;
			outcome_q <= '0;
			raddr_q   <= '0;
			rfunc_q   <= '0;
			dcount_q  <= '0;
			unique case (head.kind)
				mrtu_pkg::JOB_SEND: begin
					kind_q <= mrtu_pkg::KIND_TX;
					byte_q <= tx_byte;
					last_q <= (idx_q == mrtu_pkg::FRAME_LAST);
					if (idx_q < 3'd6) begin
						crc_q <= mrtu_pkg::crc_add(crc_base, tx_byte);
					end
				end
				mrtu_pkg::JOB_DATA: begin
					kind_q <= mrtu_pkg::KIND_DATA;
					byte_q <= head.data_byte;
				end
				mrtu_pkg::JOB_FINISH: begin
					kind_q    <= mrtu_pkg::KIND_FINISH;
					outcome_q <= head.outcome;
					raddr_q   <= head.reply_addr;
					rfunc_q   <= head.reply_func;
					dcount_q  <= head.data_count;
				end
				default: begin
					kind_q <= mrtu_pkg::KIND_REFUSE;
				end
			endcase
		end
	end

	assign out_valid  = valid_q;
	assign out_kind   = kind_q;
	assign out_byte   = byte_q;
	assign last       = last_q;
	assign outcome    = outcome_q;
	assign reply_addr = raddr_q;
	assign reply_func = rfunc_q;
	assign data_count = dcount_q;

endmodule

[design/modbus_rtu_master_transaction_unit.sv]
// Modbus RTU master transaction unit.
// Input channel (in_valid / in_stall): one item per request, command selects a received
// bus byte, a millisecond tick, or a read/write send request. One item is taken every
// cycle while the internal job queue has room; in_stall rises only when it is full.
// Output channel (out_valid / out_stall): transmit bytes of a request frame (last marks
// the eighth), reply data bytes, one finish result with its outcome, or a refusal.
// A result is registered in the job queue and then in the output register. A send
// expands to eight transmit bytes, one per cycle unless the output stalls, with the
// CRC-16 built byte by byte in the back end; every other item gives at most one result.
// Sustained input rate is one item per cycle, limited by frame expansion and output stalls.
// A stall on the output holds the current result; the front keeps taking items until
// the queue fills. cfg_wr_en / cfg_wr_data write the reply timeout in milliseconds.
// Reset (arst_n low, asynchronous) empties the queue and output, clears any pending
// transaction, marks the bus quiet and loads a timeout of 30 ms.
`timescale 1ns / 1ps
`include "modbus_rtu_master_transaction_unit_defines.svh"

module modbus_rtu_master_transaction_unit #(
	parameter int QUEUE_DEPTH = mrtu_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [9:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  slave_addr,
	input  logic [7:0]  func_code,
	input  logic [15:0] first_reg,
	input  logic [15:0] reg_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic [2:0]  outcome,
	output logic [7:0]  reply_addr,
	output logic [7:0]  reply_func,
	output logic [7:0]  data_count
);

	logic           timeout_q;
	logic [9:0]     timeout_ms_q;
	logic           accept;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;
	mrtu_pkg::job_t push_job;
	mrtu_pkg::job_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ms_q <= mrtu_pkg::TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_ms_q <= cfg_wr_data;
		end
	end

	// timeout register written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 1'b0;
		end else if (cfg_wr_en) begin
			timeout_q <= 1'b1;
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	mrtu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (command),
		.rx_byte    (rx_byte),
		.slave_addr (slave_addr),
		.func_code  (func_code),
		.first_reg  (first_reg),
		.reg_count  (reg_count),
		.timeout_ms (timeout_ms_q),
		.push       (push),
		.push_job   (push_job)
	);

	mrtu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	mrtu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.last       (last),
		.outcome    (outcome),
		.reply_addr (reply_addr),
		.reply_func (reply_func),
		.data_count (data_count)
	);

	// a frame byte that is taken is followed at once by the next one
	`MRTU_ASSERT_NEXT(a_frame_streams, clk, arst_n, out_valid && !out_stall && !last && out_kind == mrtu_pkg::KIND_TX, out_valid && out_kind == mrtu_pkg::KIND_TX)
	// last marks transmit bytes only
	`MRTU_ASSERT_IMPL(a_last_is_tx, clk, arst_n, out_valid && last, out_kind == mrtu_pkg::KIND_TX)
	// only finish results carry reply fields
	`MRTU_ASSERT_IMPL(a_fields_zero, clk, arst_n, out_valid && out_kind != mrtu_pkg::KIND_FINISH, outcome == 3'd0 && reply_addr == 8'd0 && reply_func == 8'd0 && data_count == 8'd0)
	// never pop an empty queue, never push into a full one unless a pop frees a slot
	`MRTU_ASSERT_IMPL(a_queue_guard, clk, arst_n, 1'b1, !(pop && q_empty) && !(push && q_full && !pop))
	// a configuration write lands in the timeout register
	`MRTU_ASSERT_NEXT(a_cfg_write, clk, arst_n, cfg_wr_en, timeout_q && timeout_ms_q == $past(cfg_wr_data))

endmodule
